/* src/pfe_pkg.sv */
// shared types, constants and fixed-point helpers for the phase-field energy element
// no dependencies; imported by every module of the block but pfe_chk
`default_nettype none

package pfe_pkg;

  localparam int FRAC_BITS = 20;
  localparam int RECIP_SH  = 34;

  localparam logic CFG_EPSILON     = 1'b0;
  localparam logic CFG_INV_EPSILON = 1'b1;

  localparam logic [23:0] REG_RESET = 24'd1048576;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  // ceil(2^34 / 3), exact quotient for dividends below 2^33
  localparam logic [32:0] RECIP3 = 33'd5726623062;

  // present_mask bit for each neighbour in order xm, xp, ym, yp, zm, zp
  localparam logic [5:0][2:0] MASK_BIT = {3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd0};

  typedef struct packed {
    logic             op;
    logic [23:0]      phi_c;
    logic [5:0][23:0] phi_n;
    logic [5:0]       mask;
    logic [21:0]      wt;
    logic [21:0]      wet;
  } item_t;

  typedef struct packed {
    logic             op;
    logic [23:0]      p;
    logic [27:0]      p2;
    logic [5:0][24:0] d;
    logic [2:0]       both;
    logic [24:0]      factor;
    logic [21:0]      wt;
    logic [21:0]      wet;
  } s1_t;

  typedef struct packed {
    logic             op;
    logic [23:0]      p;
    logic [27:0]      p2;
    logic [30:0]      p3;
    logic [33:0]      p4;
    logic [21:0]      wt;
    logic [21:0]      wet;
    logic [24:0]      factor;
    logic [2:0][29:0] term;
    logic [2:0][32:0] gc;
    logic [5:0][31:0] gn;
  } front_t;

  typedef struct packed {
    logic             op;
    logic [34:0]      t1;
    logic [33:0]      t2;
    logic [21:0]      wt;
    logic [24:0]      factor;
    logic [31:0]      grad2;
    logic [34:0]      gcsum;
    logic [5:0][31:0] gn;
  } mid_t;

  typedef struct packed {
    logic             op;
    logic [39:0]      u1;
    logic [38:0]      u2;
    logic [36:0]      fg;
    logic [34:0]      gcsum;
    logic [5:0][31:0] gn;
  } back_t;

  typedef struct packed {
    logic             op;
    logic             neg;
    logic [64:0]      prod;
    logic [39:0]      eb;
    logic [40:0]      gcp;
    logic [5:0][31:0] gn;
  } tail_t;

  typedef struct packed {
    logic [5:0][31:0] gn;
    logic [31:0]      gc;
    logic [31:0]      energy;
  } res_t;

  // arithmetic shift right with truncation toward zero
  function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                input int unsigned sh);
    logic signed [63:0] r;
    r = v[63] ? -((-v) >>> sh) : (v >>> sh);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/pfe_front.sv */
// first two pipeline stages: powers of phi, neighbour differences, squared
// differences and centre and neighbour gradients; depends on pfe_pkg
`default_nettype none

module pfe_front import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  item_t       item,
  input  logic [23:0] eps,
  output logic        out_valid,
  output front_t      out_data
);

  logic   v1_r, v2_r;
  s1_t    s1_r, s1_nxt;
  front_t s2_r, s2_nxt;

  logic signed [23:0] pc;
  logic signed [47:0] pp;
  logic [45:0]        fp;
  logic signed [24:0] pe;
  logic signed [24:0] ne [6];

  always_comb begin
    s1_nxt.op  = item.op;
    s1_nxt.p   = item.phi_c;
    s1_nxt.wt  = item.wt;
    s1_nxt.wet = item.wet;
    pc = signed'(item.phi_c);
    pp = pc * pc;
    s1_nxt.p2 = 28'(shr_tz(64'(pp), FRAC_BITS));
    pe = pc;
    for (int k = 0; k < 6; k++) begin
      ne[k] = signed'(item.phi_n[k]);
      s1_nxt.d[k] = item.mask[MASK_BIT[k]] ? 25'(pe - ne[k]) : '0;
    end
    s1_nxt.both[0] = item.mask[0] & item.mask[5];
    s1_nxt.both[1] = item.mask[1] & item.mask[4];
    s1_nxt.both[2] = item.mask[2] & item.mask[3];
    fp = eps * item.wt;
    s1_nxt.factor = 25'(fp >> (FRAC_BITS + 1));
  end

  logic signed [27:0] p2s;
  logic signed [23:0] ps;
  logic signed [51:0] p3p;
  logic signed [55:0] p4p;
  logic signed [24:0] dm, dp;
  logic signed [25:0] dsum, fs;
  logic signed [49:0] sqm, sqp;
  logic [29:0]        sq;
  logic signed [50:0] gmp, gpp;
  logic signed [51:0] gcp;
  logic signed [31:0] gm, gp;
  logic signed [32:0] gc;

  always_comb begin
    s2_nxt.op     = s1_r.op;
    s2_nxt.p      = s1_r.p;
    s2_nxt.p2     = s1_r.p2;
    s2_nxt.wt     = s1_r.wt;
    s2_nxt.wet    = s1_r.wet;
    s2_nxt.factor = s1_r.factor;
    p2s = signed'(s1_r.p2);
    ps  = signed'(s1_r.p);
    p3p = p2s * ps;
    p4p = p2s * p2s;
    s2_nxt.p3 = 31'(shr_tz(64'(p3p), FRAC_BITS));
    s2_nxt.p4 = 34'(shr_tz(64'(p4p), FRAC_BITS));
    fs = signed'({1'b0, s1_r.factor});
    for (int a = 0; a < 3; a++) begin
      dm   = signed'(s1_r.d[2*a]);
      dp   = signed'(s1_r.d[2*a+1]);
      dsum = 26'(dm) + 26'(dp);
      sqm  = dm * dm;
      sqp  = dp * dp;
      sq   = 30'(shr_tz(64'(sqm), FRAC_BITS)) + 30'(shr_tz(64'(sqp), FRAC_BITS));
      gmp  = fs * dm;
      gpp  = fs * dp;
      gcp  = fs * dsum;
      gm   = 32'(shr_tz(64'(gmp), FRAC_BITS));
      gp   = 32'(shr_tz(64'(gpp), FRAC_BITS));
      gc   = 33'(shr_tz(64'(gcp), FRAC_BITS));
      // one-sided axis counts double
      if (!s1_r.both[a]) begin
        gm = gm <<< 1;
        gp = gp <<< 1;
        gc = gc <<< 1;
      end
      s2_nxt.term[a]    = s1_r.both[a] ? (sq >> 1) : sq;
      s2_nxt.gc[a]      = gc;
      s2_nxt.gn[2*a]    = s1_r.op ? '0 : -gm;
      s2_nxt.gn[2*a+1]  = s1_r.op ? '0 : -gp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = s2_r;

endmodule

`default_nettype wire

/* src/pfe_back.sv */
// stages three and four: well polynomial scaled by weight and inverse width,
// wetting by wetting and weight, gradient-energy product; depends on pfe_pkg
`default_nettype none

module pfe_back import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  front_t      in_data,
  input  logic [23:0] ieps,
  output logic        out_valid,
  output back_t       out_data
);

  logic  v3_r, v4_r;
  mid_t  s3_r, s3_nxt;
  back_t s4_r, s4_nxt;

  logic signed [32:0] p3e, pe;
  logic signed [34:0] p2e, p4e, well;
  logic signed [32:0] poly;
  logic signed [31:0] p3mp;
  logic signed [28:0] pm1;
  logic signed [21:0] wets;
  logic signed [22:0] wts;
  logic signed [54:0] pa, pd;
  logic signed [57:0] pb;
  logic signed [50:0] pc;

  always_comb begin
    p3e  = signed'(in_data.p3);
    pe   = signed'(in_data.p);
    p2e  = signed'(in_data.p2);
    p4e  = signed'(in_data.p4);
    poly = p3e - pe - pe - pe - 33'(ONE <<< 1);
    well = p4e - p2e - p2e + 35'(ONE);
    p3mp = 32'(p3e - pe);
    pm1  = 29'(p2e - 35'(ONE));
    wets = signed'(in_data.wet);
    wts  = signed'({1'b0, in_data.wt});
    pa   = wets * poly;
    pb   = well * wts;
    pc   = wets * pm1;
    pd   = p3mp * wts;
    s3_nxt.op     = in_data.op;
    s3_nxt.t1     = in_data.op ? 35'(shr_tz(64'(pa), FRAC_BITS))
                               : 35'(shr_tz(64'(pb), FRAC_BITS));
    s3_nxt.t2     = in_data.op ? 34'(shr_tz(64'(pc), FRAC_BITS))
                               : 34'(shr_tz(64'(pd), FRAC_BITS));
    s3_nxt.wt     = in_data.wt;
    s3_nxt.factor = in_data.factor;
    s3_nxt.grad2  = 32'(in_data.term[0]) + 32'(in_data.term[1]) + 32'(in_data.term[2]);
    s3_nxt.gcsum  = 35'(signed'(in_data.gc[0])) + 35'(signed'(in_data.gc[1]))
                  + 35'(signed'(in_data.gc[2]));
    s3_nxt.gn     = in_data.gn;
  end

  logic signed [24:0] m;
  logic signed [34:0] t1s;
  logic signed [33:0] t2s;
  logic signed [59:0] q1;
  logic signed [58:0] q2;
  logic [56:0]        fgp;

  always_comb begin
    // surface scales by area, bulk by inverse width
    m   = s3_r.op ? signed'({3'b0, s3_r.wt}) : signed'({1'b0, ieps});
    t1s = signed'(s3_r.t1);
    t2s = signed'(s3_r.t2);
    q1  = t1s * m;
    q2  = t2s * m;
    fgp = s3_r.factor * s3_r.grad2;
    s4_nxt.op    = s3_r.op;
    s4_nxt.u1    = 40'(shr_tz(64'(q1), FRAC_BITS));
    s4_nxt.u2    = 39'(shr_tz(64'(q2), FRAC_BITS));
    s4_nxt.fg    = 37'(fgp >> FRAC_BITS);
    s4_nxt.gcsum = s3_r.gcsum;
    s4_nxt.gn    = s3_r.gn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

`default_nettype wire

/* src/pfe_out.sv */
// stages five and six: division by the constants, final sums and 32-bit
// saturation into the result register; depends on pfe_pkg
`default_nettype none

module pfe_out import pfe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  back_t in_data,
  output logic  out_valid,
  output res_t  out_data
);

  logic  v5_r, v6_r;
  tail_t s5_r, s5_nxt;
  res_t  s6_r, s6_nxt;

  logic signed [39:0] u1s;
  logic signed [38:0] u2s;
  logic signed [34:0] gcs;
  logic [39:0]        mag;
  logic [31:0]        mag1;

  always_comb begin
    u1s  = signed'(in_data.u1);
    u2s  = signed'(in_data.u2);
    gcs  = signed'(in_data.gcsum);
    mag  = u1s[39] ? 40'(-u1s) : in_data.u1;
    mag1 = 32'(mag >> 1);
    s5_nxt.op   = in_data.op;
    s5_nxt.neg  = u1s[39];
    // divide by three through the reciprocal after halving
    s5_nxt.prod = 65'(mag1) * 65'(RECIP3);
    s5_nxt.eb   = 40'(shr_tz(64'(u1s), 2)) + signed'({3'b0, in_data.fg});
    s5_nxt.gcp  = in_data.op ? 41'(shr_tz(64'(u2s), 1)) : 41'(u2s) + 41'(gcs);
    s5_nxt.gn   = in_data.gn;
  end

  logic [30:0]        q;
  logic signed [31:0] qs;

  always_comb begin
    q  = s5_r.prod[64:RECIP_SH];
    qs = signed'({1'b0, q});
    s6_nxt.energy = s5_r.op ? (s5_r.neg ? -qs : qs) : sat32(64'(signed'(s5_r.eb)));
    s6_nxt.gc     = sat32(64'(signed'(s5_r.gcp)));
    s6_nxt.gn     = s5_r.gn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= in_valid;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = s6_r;

endmodule

`default_nettype wire

/* src/phase_field_energy_element_core.sv */
// top level of the phase-field energy element: stream ports, configuration
// registers and the six-stage pipeline; depends on pfe_pkg, pfe_front, pfe_back, pfe_out
//
// Takes one element per clock while the output side is not stalled and returns
// its result from the last stage register; throughput is one element per cycle
// while not stalled, set by the six-stage multiplier pipeline. The whole
// pipeline holds while a result waits on out_tready, and in_tready follows (no
// result waiting or out_tready high). Write epsilon (index 0) and inv_epsilon
// (index 1) only while no element is in flight.
`default_nettype none

module phase_field_energy_element_core import pfe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // phi_center, phi_xm, phi_xp, phi_ym, phi_yp, phi_zm, phi_zp, present_mask,
  // weight, wetting, zero pad
  input  logic [223:0] in_tdata,
  // opcode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // energy, grad_center, grad_xm, grad_xp, grad_ym, grad_yp, grad_zm, grad_zp
  output logic [255:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [23:0]  cfg_wdata
);

  logic [23:0] eps_r, ieps_r;
  logic        en;
  item_t       item;
  logic        v_front, v_back;
  front_t      d_front;
  back_t       d_back;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= REG_RESET;
      ieps_r <= REG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_EPSILON:     eps_r  <= cfg_wdata;
        CFG_INV_EPSILON: ieps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign item.op       = in_tuser;
  assign item.phi_c    = in_tdata[23:0];
  assign item.phi_n    = in_tdata[167:24];
  assign item.mask     = in_tdata[173:168];
  assign item.wt       = in_tdata[195:174];
  assign item.wet      = in_tdata[217:196];

  pfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .item      (item),
    .eps       (eps_r),
    .out_valid (v_front),
    .out_data  (d_front)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_front),
    .in_data   (d_front),
    .ieps      (ieps_r),
    .out_valid (v_back),
    .out_data  (d_back)
  );

  pfe_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_back),
    .in_data   (d_back),
    .out_valid (out_tvalid),
    .out_data  (res)
  );

  assign out_tdata = {res.gn, res.gc, res.energy};

endmodule

`default_nettype wire

/* src/pfe_chk.sv */
// port-level checks for the phase-field energy element, bound to the top level
// depends on phase_field_energy_element_core
`default_nettype none

module pfe_chk (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [255:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow pipeline stall");

endmodule

bind phase_field_energy_element_core pfe_chk u_chk (.*);

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for phase_field_energy_element_core: random and directed
// elements, a bit-accurate fixed-point predictor and a scoreboard of packed results
// depends on pfe_pkg and the core RTL only
`default_nettype none

module tb;
  import pfe_pkg::CFG_EPSILON;
  import pfe_pkg::CFG_INV_EPSILON;

  localparam int FB = 20;
  localparam longint SAT62 = 64'sd4611686018427387903;
  localparam longint UNIT = 64'sd1 <<< FB;
  localparam logic OP_BULK = 1'b0;
  localparam logic OP_SURF = 1'b1;

  typedef struct {
    logic                op;
    logic signed [23:0]  phi_c;
    logic signed [23:0]  phi_n [6];  // xm, xp, ym, yp, zm, zp
    logic [5:0]          mask;
    logic [21:0]         wt;
    logic signed [21:0]  wet;
  } element_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [255:0] out_tdata;
  logic         cfg_we;
  logic         cfg_addr;
  logic [23:0]  cfg_wdata;

  phase_field_energy_element_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  element_t     pending_elems [$];
  logic [255:0] expected_results [$];
  element_t     drv_elem;
  logic [23:0]  eps_model;
  logic [23:0]  inv_eps_model;
  int           mismatches;
  bit           in_accepted;
  bit           no_idle;
  int           send_gap;
  int           recv_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint sat62(input longint v);
    if (v > SAT62) return SAT62;
    if (v < -SAT62) return -SAT62;
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] prod;
    logic [63:0]  mag;
    longint       x;
    longint       y;
    x = a < 0 ? -a : a;
    y = b < 0 ? -b : b;
    prod = {64'd0, x} * {64'd0, y};
    if ((prod >> (64 + FB)) != 0) mag = SAT62;
    else begin
      mag = 64'(prod >> FB);
      if (mag > SAT62) mag = SAT62;
    end
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return 32'(v);
  endfunction

  function automatic logic [223:0] pack_element(input element_t e);
    logic [223:0] d;
    d = '0;
    d[23:0] = e.phi_c;
    for (int n = 0; n < 6; n++) d[24 + 24*n +: 24] = e.phi_n[n];
    d[173:168] = e.mask;
    d[195:174] = e.wt;
    d[217:196] = e.wet;
    return d;
  endfunction

  function automatic logic [255:0] element_energy(input element_t e);
    longint       res [8];
    longint       p, p2, p3, p4, wt, wet, eps, ieps, poly, well, factor, grad2, g_c;
    longint       dm, dp, sq, gc, gm, gp;
    bit           hm, hp;
    int           bit_m [3];
    int           bit_p [3];
    logic [255:0] r;
    bit_m = '{0, 1, 2};
    bit_p = '{5, 4, 3};
    p = e.phi_c;
    wt = longint'(e.wt);
    wet = e.wet;
    eps = longint'(eps_model);
    ieps = longint'(inv_eps_model);
    p2 = fx_mul(p, p);
    p3 = fx_mul(p2, p);
    for (int k = 0; k < 8; k++) res[k] = 0;
    if (e.op == OP_SURF) begin
      poly = sat62(sat62(p3 - sat62(sat62(p + p) + p)) - 2 * UNIT);
      res[0] = fx_mul(fx_mul(wet, poly), wt) / 6;
      res[1] = fx_mul(fx_mul(wet, sat62(p2 - UNIT)), wt) / 2;
    end else begin
      p4 = fx_mul(p2, p2);
      well = sat62(sat62(p4 - sat62(p2 + p2)) + UNIT);
      res[0] = fx_mul(fx_mul(well, wt), ieps) / 4;
      g_c = fx_mul(fx_mul(sat62(p3 - p), wt), ieps);
      factor = fx_mul(eps, wt) / 2;
      grad2 = 0;
      for (int a = 0; a < 3; a++) begin
        hm = e.mask[bit_m[a]];
        hp = e.mask[bit_p[a]];
        dm = hm ? p - longint'(e.phi_n[2*a]) : 0;
        dp = hp ? p - longint'(e.phi_n[2*a + 1]) : 0;
        sq = sat62(fx_mul(dm, dm) + fx_mul(dp, dp));
        gc = fx_mul(factor, dm + dp);
        gm = fx_mul(factor, dm);
        gp = fx_mul(factor, dp);
        if (hm && hp) grad2 = sat62(grad2 + sq / 2);
        else begin
          grad2 = sat62(grad2 + sq);
          gc = sat62(gc + gc);
          gm = sat62(gm + gm);
          gp = sat62(gp + gp);
        end
        g_c = sat62(g_c + gc);
        res[2 + 2*a] = -gm;
        res[3 + 2*a] = -gp;
      end
      res[0] = sat62(res[0] + fx_mul(factor, grad2));
      res[1] = g_c;
    end
    for (int k = 0; k < 8; k++) r[32*k +: 32] = clip32(res[k]);
    return r;
  endfunction

  function automatic void queue_elem(input element_t e);
    pending_elems.insert(pending_elems.size(), e);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // input side: transfer accepted at posedge, next item driven at negedge
  always @(posedge clk) begin
    in_accepted = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      in_accepted = 1'b1;
      expected_results.insert(expected_results.size(), element_energy(drv_elem));
    end
  end

  always @(negedge clk) begin
    element_t e;
    bit       busy;
    busy = in_tvalid && !in_accepted;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!busy) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_elems.size() > 0) begin
        e = pending_elems.pop_front();
        drv_elem = e;
        in_tdata <= pack_element(e);
        in_tuser <= e.op;
        in_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready) recv_gap <= pick_gap();
    end
  end

  always @(posedge clk) begin
    logic [255:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (out_tdata[32*k +: 32] !== want[32*k +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h actual %h", k, want[32*k +: 32],
                       out_tdata[32*k +: 32]);
          end
        end
      end
    end
  end

  function automatic element_t rand_element(input bit wild);
    element_t e;
    e.op = 1'($urandom_range(1));
    if (wild) begin
      e.phi_c = 24'($urandom);
      for (int n = 0; n < 6; n++) e.phi_n[n] = 24'($urandom);
      e.wt = 22'($urandom);
      e.wet = 22'($urandom);
    end else begin
      e.phi_c = 24'($urandom_range(2 * UNIT) - UNIT + $urandom_range(1023));
      for (int n = 0; n < 6; n++) e.phi_n[n] = 24'($urandom_range(2 * UNIT) - UNIT);
      e.wt = 22'($urandom_range(2097152));
      e.wet = 22'($urandom_range(2 * 1482911) - 1482911);
    end
    e.mask = 6'($urandom);
    return e;
  endfunction

  function automatic element_t make_element(input logic op, input logic signed [23:0] pc,
                                            input logic signed [23:0] pn, input logic [5:0] m,
                                            input logic [21:0] w, input logic signed [21:0] wet);
    element_t e;
    e.op = op;
    e.phi_c = pc;
    for (int n = 0; n < 6; n++) e.phi_n[n] = n[0] ? -pn : pn;
    e.mask = m;
    e.wt = w;
    e.wet = wet;
    return e;
  endfunction

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EPSILON) eps_model = val;
    else inv_eps_model = val;
  endtask

  task automatic drain();
    while (!(pending_elems.size() == 0 && !in_tvalid && expected_results.size() == 0))
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    logic [23:0] eps_set [4];
    logic [23:0] ieps_set [4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_EPSILON;
    cfg_wdata = '0;
    eps_model = 24'd1048576;
    inv_eps_model = 24'd1048576;
    mismatches = 0;
    no_idle = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset configuration
    queue_elem(make_element(OP_BULK, 0, 0, 6'h3f, 1048576, 0));
    queue_elem(make_element(OP_BULK, 24'sh7fffff, 24'sh7fffff, 6'h3f,
                            22'h3fffff, 22'sh1fffff));
    queue_elem(make_element(OP_BULK, -24'sh800000, 24'sh7fffff, 6'h3f,
                            22'h3fffff, -22'sh200000));
    queue_elem(make_element(OP_BULK, 1048576, -1048576, 6'h00, 2097152, 0));
    queue_elem(make_element(OP_BULK, -1048576, 524288, 6'h01, 2097152, 0));
    queue_elem(make_element(OP_BULK, 300000, -700000, 6'h20, 1048576, 0));
    queue_elem(make_element(OP_BULK, 300000, -700000, 6'h12, 1048576, 0));
    queue_elem(make_element(OP_BULK, 300000, 900000, 6'h0c, 1048576, 0));
    queue_elem(make_element(OP_BULK, 123456, 654321, 6'h2a, 0, 0));
    queue_elem(make_element(OP_SURF, 0, 24'sh7fffff, 6'h3f, 1048576, 1482911));
    queue_elem(make_element(OP_SURF, 1048576, 0, 6'h00, 2097152, -1482911));
    queue_elem(make_element(OP_SURF, -1048576, 0, 6'h15, 2097152, 1482911));
    queue_elem(make_element(OP_SURF, 24'sh7fffff, 0, 6'h00, 22'h3fffff,
                            22'sh1fffff));
    queue_elem(make_element(OP_SURF, -24'sh800000, 0, 6'h00, 22'h3fffff,
                            -22'sh200000));
    queue_elem(make_element(OP_SURF, 500000, 0, 6'h3f, 0, 1000000));
    drain();

    eps_set = '{24'd1, 24'hffffff, 24'd1048576, 24'd0};
    ieps_set = '{24'hffffff, 24'd1, 24'd524288, 24'd0};
    eps_set[3] = 24'($urandom_range(24'hffffff, 1));
    ieps_set[3] = 24'($urandom_range(24'hffffff, 1));
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_EPSILON, eps_set[ph]);
      write_reg(CFG_INV_EPSILON, ieps_set[ph]);
      no_idle = (ph == 2);
      for (int i = 0; i < 500; i++)
        queue_elem(rand_element($urandom_range(9) < 2));
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/pfe_pkg.sv
src/pfe_front.sv
src/pfe_back.sv
src/pfe_out.sv
src/phase_field_energy_element_core.sv
src/pfe_chk.sv
dv/tb.sv
